// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file psc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define PSC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PSC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/psc_pkg.sv
`default_nettype none

package psc_pkg;

    localparam int unsigned VEL_W       = 32;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned FRAME_W     = 8;
    localparam int unsigned SPEED_W     = 23;
    localparam int unsigned NUM_W       = 31;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned GLOW_W      = 4;
    localparam int unsigned COLOUR_W    = 16;
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned DIV_STAGES  = LEVEL_W;

    localparam logic [SPEED_W-1:0] RED_SPEED_RST = 23'd196608;

    localparam int unsigned SEG_LO_DIV = 255;
    localparam int unsigned SEG_HI_DIV = 254;

    // Remainder, partial level and glow travel together through the divider.
    typedef struct packed {
        logic [NUM_W-1:0]   rem;
        logic [LEVEL_W-1:0] quo;
        logic [GLOW_W-1:0]  glow;
    } t_div_word;

    typedef logic [255:0][23:0] t_rgb_table;

    // Two-segment colour ramp, one {r,g,b} entry per level.
    function automatic t_rgb_table build_rgb_table();
        t_rgb_table tbl;
        int         blend;
        int         r;
        int         g;
        int         b;
        for (int lv = 0; lv < 256; lv++) begin
            if (lv < 128) begin
                blend = lv * 2;
                r = 52 + (blend * 98) / SEG_LO_DIV;
                g = 10 + (blend * 20) / SEG_LO_DIV;
                b = 92 + (blend * 118) / SEG_LO_DIV;
            end else begin
                blend = (lv - 128) * 2;
                r = 150 + (blend * 96) / SEG_HI_DIV;
                g = 30 + (blend * 64) / SEG_HI_DIV;
                b = 210 + (blend * 45) / SEG_HI_DIV;
            end
            tbl[lv] = {r[7:0], g[7:0], b[7:0]};
        end
        return tbl;
    endfunction

    localparam t_rgb_table RGB_TABLE = build_rgb_table();

endpackage

`default_nettype wire

// File: rtl/core/psc_front.sv
`default_nettype none

// Three stages: magnitudes and pulse glow, speed estimate and clamp, level numerator.
module psc_front
    import psc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [SPEED_W-1:0]        i_red_speed,
    input  wire logic                      i_vld,
    output      logic                      o_rdy,
    input  wire logic signed [VEL_W-1:0]   i_vel_x,
    input  wire logic signed [VEL_W-1:0]   i_vel_y,
    input  wire logic [IDX_W-1:0]          i_particle_index,
    input  wire logic [FRAME_W-1:0]        i_frame_low,
    output      logic                      o_vld,
    input  wire logic                      i_rdy,
    output      t_div_word                 o_word
);

    logic                 r_v1, r_v2, r_v3;
    logic                 rdy1, rdy2, rdy3;
    logic [VEL_W-1:0]     r_ax, r_ay;
    logic [GLOW_W-1:0]    r_glow1, r_glow2, r_glow3;
    logic [SPEED_W-1:0]   r_speed;
    logic [NUM_W-1:0]     r_num;

    logic [VEL_W-1:0]     n_ax, n_ay;
    logic [7:0]           phase;
    logic [7:0]           pulse;
    logic [VEL_W-1:0]     hi, lo, speed_raw;
    logic [SPEED_W-1:0]   n_speed;
    logic [NUM_W-1:0]     n_num;

    assign rdy3  = !r_v3 || i_rdy;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_rdy = rdy1;

    always_comb begin
        n_ax  = i_vel_x[VEL_W-1] ? (~i_vel_x + 1'b1) : i_vel_x;
        n_ay  = i_vel_y[VEL_W-1] ? (~i_vel_y + 1'b1) : i_vel_y;
        phase = 8'(i_frame_low * 8'd3 + i_particle_index[7:0] * 8'd47);
        // falling half of the triangle mirrors the phase
        pulse = phase[7] ? ~phase : phase;
    end

    always_comb begin
        hi        = (r_ax > r_ay) ? r_ax : r_ay;
        lo        = (r_ax > r_ay) ? r_ay : r_ax;
        speed_raw = hi + (lo >> 1);
        n_speed   = (speed_raw > VEL_W'(i_red_speed)) ? i_red_speed
                                                       : speed_raw[SPEED_W-1:0];
    end

    // speed*255 + red_speed/2, below 2^31
    assign n_num = NUM_W'({r_speed, 8'b0}) - NUM_W'(r_speed)
                 + NUM_W'(i_red_speed >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_vld;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_glow1 <= pulse[6:3];
        end
        if (rdy2) begin
            r_speed <= n_speed;
            r_glow2 <= r_glow1;
        end
        if (rdy3) begin
            r_num   <= n_num;
            r_glow3 <= r_glow2;
        end
    end

    assign o_vld       = r_v3;
    assign o_word.rem  = r_num;
    assign o_word.quo  = '0;
    assign o_word.glow = r_glow3;

endmodule

`default_nettype wire

// File: rtl/core/psc_div_stage.sv
`default_nettype none

// One restoring step of the level division: settles quotient bit SHIFT.
module psc_div_stage
    import psc_pkg::*;
#(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [SPEED_W-1:0]  i_red_speed,
    input  wire logic                i_vld,
    output      logic                o_rdy,
    input  wire t_div_word           i_word,
    output      logic                o_vld,
    input  wire logic                i_rdy,
    output      t_div_word           o_word
);

    logic             r_vld;
    t_div_word        r_word;
    t_div_word        n_word;
    logic [NUM_W-1:0] dsr;

    assign dsr   = NUM_W'(i_red_speed) << SHIFT;
    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        n_word = i_word;
        if (i_word.rem >= dsr) begin
            n_word.rem        = i_word.rem - dsr;
            n_word.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

`default_nettype wire

// File: rtl/core/psc_shade.sv
`default_nettype none

// Ramp lookup, glow add with saturation, RGB565 pack into the output register.
module psc_shade
    import psc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    output      logic                 o_rdy,
    input  wire t_div_word            i_word,
    output      logic                 o_vld,
    input  wire logic                 i_rdy,
    output      logic [COLOUR_W-1:0]  o_colour
);

    logic                r_vld;
    logic [COLOUR_W-1:0] r_colour;
    logic [23:0]         base;
    logic [8:0]          r_sum, g_sum, b_sum;
    logic [7:0]          r_ch, g_ch, b_ch;
    logic [COLOUR_W-1:0] n_colour;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        base  = RGB_TABLE[i_word.quo];
        r_sum = {1'b0, base[23:16]} + 9'(i_word.glow);
        g_sum = {1'b0, base[15:8]}  + 9'(i_word.glow >> 1);
        b_sum = {1'b0, base[7:0]}   + 9'(i_word.glow);
        r_ch  = r_sum[8] ? 8'hFF : r_sum[7:0];
        g_ch  = g_sum[8] ? 8'hFF : g_sum[7:0];
        b_ch  = b_sum[8] ? 8'hFF : b_sum[7:0];
        n_colour = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_colour <= n_colour;
        end
    end

    assign o_vld    = r_vld;
    assign o_colour = r_colour;

endmodule

`default_nettype wire

// File: rtl/core/particle_speed_colour_unit.sv
// Channel   | Dir | Signals               | Payload
// s_axis    | in  | tvalid/tready/tdata   | vel_x, vel_y, particle_index, frame_low
// m_axis    | out | tvalid/tready/tdata   | colour (RGB565)
// cfg       | in  | we/wdata              | red_speed
//
// One item per cycle while the output is not stalled; registers in order: 3 front
// stages, 8 divider stages (one level bit each), 1 output register.
// Every stage has its own valid bit; a stage loads when it is empty or the next
// one moves, so bubbles close up behind a stalled output.
// Synchronous active-low reset clears valid bits and restores red_speed.
`default_nettype none

module particle_speed_colour_unit
    import psc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [SPEED_W-1:0]    i_cfg_wdata,     // red_speed
    input  wire logic                  i_s_axis_tvalid,
    output      logic                  o_s_axis_tready,
    // [31:0] vel_x, [63:32] vel_y, [73:64] particle_index, [81:74] frame_low
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    output      logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output      logic [COLOUR_W-1:0]   o_m_axis_tdata   // [15:0] colour
);

    logic [SPEED_W-1:0] r_red_speed;
    logic               vld [DIV_STAGES+1];
    logic               rdy [DIV_STAGES+1];
    t_div_word          word [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_speed <= RED_SPEED_RST;
        end else if (i_cfg_we) begin
            r_red_speed <= i_cfg_wdata;
        end
    end

    psc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_red_speed      (r_red_speed),
        .i_vld            (i_s_axis_tvalid),
        .o_rdy            (o_s_axis_tready),
        .i_vel_x          (i_s_axis_tdata[31:0]),
        .i_vel_y          (i_s_axis_tdata[63:32]),
        .i_particle_index (i_s_axis_tdata[73:64]),
        .i_frame_low      (i_s_axis_tdata[81:74]),
        .o_vld            (vld[0]),
        .i_rdy            (rdy[0]),
        .o_word           (word[0])
    );

    // most significant level bit first
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        psc_div_stage #(
            .SHIFT (DIV_STAGES - 1 - g)
        ) u_div (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_red_speed (r_red_speed),
            .i_vld       (vld[g]),
            .o_rdy       (rdy[g]),
            .i_word      (word[g]),
            .o_vld       (vld[g+1]),
            .i_rdy       (rdy[g+1]),
            .o_word      (word[g+1])
        );
    end

    psc_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (vld[DIV_STAGES]),
        .o_rdy    (rdy[DIV_STAGES]),
        .i_word   (word[DIV_STAGES]),
        .o_vld    (o_m_axis_tvalid),
        .i_rdy    (i_m_axis_tready),
        .o_colour (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/psc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module psc_checker
    import psc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [COLOUR_W-1:0]   o_m_axis_tdata
);

    // output holds a stalled transfer
    `PSC_ASSERT_CLK(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output valid dropped while stalled")
    `PSC_ASSERT_CLK(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "output data changed while stalled")
    // empty output stage means the whole pipe can take an item
    `PSC_ASSERT_CLK(a_rdy_empty, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output")
    `PSC_ASSERT_CLK(a_rdy_sink, i_m_axis_tready |-> o_s_axis_tready, "input stalled while sink is ready")
    `PSC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind particle_speed_colour_unit psc_checker u_psc_checker (.*);

`default_nettype wire

// File: tb/sv/particle_speed_colour_unit_tb.sv
`timescale 1ns / 100ps

module particle_speed_colour_unit_tb;
    import psc_pkg::SPEED_W;
    import psc_pkg::IN_TDATA_W;
    import psc_pkg::COLOUR_W;
    import psc_pkg::RED_SPEED_RST;

    localparam int  RANDOM_PER_PHASE = 105;
    localparam int  MAX_IDLE         = 11;
    localparam int  DRAIN_CYCLES     = 24;
    localparam real RUN_LIMIT_NS     = 5_000_000.0;

    localparam logic [SPEED_W-1:0] RED_SPEED_MIN = 23'd1;
    localparam logic [SPEED_W-1:0] RED_SPEED_MAX = 23'h7F_FFFF;

    localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN = 32'h8000_0000;

    // One input transfer, packed from the lowest tdata bit up.
    typedef struct packed {
        logic [7:0]  frame_low;
        logic [9:0]  particle_index;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
    } t_particle;

    typedef struct {
        t_particle             item;
        bit                    known;
        logic [COLOUR_W-1:0]   colour;
    } t_dir_row;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [SPEED_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [COLOUR_W-1:0]   m_tdata;

    logic [COLOUR_W-1:0] colour_q[$];
    t_dir_row            dir_rows[$];
    logic [SPEED_W-1:0]  red_speed_settings[$];
    logic [SPEED_W-1:0]  cur_red_speed = RED_SPEED_RST;
    int                  errors        = 0;
    bit                  src_burst     = 1'b0;
    bit                  snk_burst     = 1'b0;

    particle_speed_colour_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [COLOUR_W-1:0] predict_colour(input t_particle p,
                                                           input logic [SPEED_W-1:0] rs);
        logic [31:0]     ax;
        logic [31:0]     ay;
        logic [31:0]     hi;
        logic [31:0]     lo;
        longint unsigned speed;
        int unsigned     level;
        int unsigned     blend;
        int unsigned     r;
        int unsigned     g;
        int unsigned     b;
        int unsigned     phase;
        int unsigned     pulse;
        int unsigned     glow;
        logic [7:0]      rc;
        logic [7:0]      gc;
        logic [7:0]      bc;
        ax    = p.vel_x[31] ? (~p.vel_x + 32'd1) : p.vel_x;
        ay    = p.vel_y[31] ? (~p.vel_y + 32'd1) : p.vel_y;
        hi    = (ax > ay) ? ax : ay;
        lo    = (ax > ay) ? ay : ax;
        speed = 64'(hi) + 64'(lo >> 1);
        // a zero divisor reads as saturated
        if (rs == '0) begin
            level = 255;
        end else begin
            if (speed > 64'(rs))
                speed = 64'(rs);
            level = int'((speed * 255 + 64'(rs >> 1)) / 64'(rs));
            if (level > 255)
                level = 255;
        end
        if (level < 128) begin
            blend = level << 1;
            r = 52 + (blend * 98) / 255;
            g = 10 + (blend * 20) / 255;
            b = 92 + (blend * 118) / 255;
        end else begin
            blend = (level - 128) << 1;
            r = 150 + (blend * 96) / 254;
            g = 30 + (blend * 64) / 254;
            b = 210 + (blend * 45) / 254;
        end
        phase = (32'(p.frame_low) * 3 + 32'(p.particle_index) * 47) & 32'hFF;
        pulse = (phase < 128) ? phase : 255 - phase;
        glow  = pulse >> 3;
        r = r + glow;
        g = g + (glow >> 1);
        b = b + glow;
        rc = (r > 255) ? 8'hFF : 8'(r);
        gc = (g > 255) ? 8'hFF : 8'(g);
        bc = (b > 255) ? 8'hFF : 8'(b);
        return {rc[7:3], gc[7:2], bc[7:3]};
    endfunction

    function automatic void add_row(input logic [31:0] vx, input logic [31:0] vy,
                                    input logic [9:0] idx, input logic [7:0] frame,
                                    input bit known, input logic [COLOUR_W-1:0] colour);
        t_dir_row row;
        row.item.vel_x          = vx;
        row.item.vel_y          = vy;
        row.item.particle_index = idx;
        row.item.frame_low      = frame;
        row.known               = known;
        row.colour              = colour;
        dir_rows.push_back(row);
    endfunction

    // Returns at the edge that took the transfer; tvalid is left high so a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_particle(input t_particle p, input logic [COLOUR_W-1:0] want);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(p);
        do @(posedge clk); while (!s_tready);
        colour_q.push_back(want);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (colour_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_red_speed(input logic [SPEED_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        cur_red_speed  = value;
    endtask

    initial begin : stimulus
        t_particle           p;
        logic [31:0]         lim;
        logic [31:0]         mag;
        logic [COLOUR_W-1:0] want;

        // directed rows, red_speed at its reset value
        add_row(32'd0,     32'd0,      10'd0,    8'd0,   1'b1, 16'h304B);
        add_row(VEL_MIN,   VEL_MIN,    10'd0,    8'd0,   1'b1, 16'hF2FF);
        add_row(VEL_MAX,   VEL_MAX,    10'd0,    8'd0,   1'b1, 16'hF2FF);
        add_row(32'd0,     32'd0,      10'd0,    8'd213, 1'b1, 16'h408D);  // pulse peak
        add_row(VEL_MIN,   32'd0,      10'd0,    8'd213, 1'b1, 16'hFB3F);  // channels clip
        add_row(32'd0,     32'hFFFF_FFFF, 10'd0, 8'd0,   1'b0, '0);
        add_row(32'd196608, 32'd0,     10'd0,    8'd0,   1'b0, '0);
        add_row(32'd98304, 32'd0,      10'd0,    8'd0,   1'b0, '0);        // ramp switch
        add_row(32'd97536, 32'd0,      10'd0,    8'd0,   1'b0, '0);
        add_row(-32'sd5000, 32'd70000, 10'd7,    8'd3,   1'b0, '0);
        add_row(32'd65536, 32'd65536,  10'd1023, 8'd255, 1'b0, '0);
        add_row(32'd1000,  32'd2000,   10'd0,    8'd128, 1'b0, '0);        // falling pulse
        add_row(32'hFFFF_FFFF, 32'd1,  10'd512,  8'd1,   1'b0, '0);
        add_row(VEL_MAX,   VEL_MIN,    10'd341,  8'd170, 1'b0, '0);
        add_row(32'd130000, -32'sd40000, 10'd85, 8'd77,  1'b0, '0);
        add_row(32'd0,     32'd50000,  10'd600,  8'd42,  1'b0, '0);

        red_speed_settings.push_back(RED_SPEED_MIN);
        red_speed_settings.push_back(RED_SPEED_MAX);
        red_speed_settings.push_back('0);
        red_speed_settings.push_back(RED_SPEED_RST);
        red_speed_settings.push_back(SPEED_W'($urandom_range(2, 1000)));
        red_speed_settings.push_back(SPEED_W'($urandom_range(1, RED_SPEED_MAX)));
        red_speed_settings.push_back(SPEED_W'($urandom_range(1, RED_SPEED_MAX)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            src_burst = (i < 4);
            want = dir_rows[i].known ? dir_rows[i].colour
                                     : predict_colour(dir_rows[i].item, cur_red_speed);
            send_particle(dir_rows[i].item, want);
        end

        foreach (red_speed_settings[s]) begin
            drain();
            write_red_speed(red_speed_settings[s]);
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            // mostly speeds around the saturation point, some full-range noise
            lim = (cur_red_speed == '0) ? 32'hFFFF_FFFF : 32'(cur_red_speed) * 2;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    p.vel_x = $urandom;
                    p.vel_y = $urandom;
                end else begin
                    mag     = $urandom_range(0, lim);
                    p.vel_x = $urandom_range(0, 1) ? -mag : mag;
                    mag     = $urandom_range(0, lim);
                    p.vel_y = $urandom_range(0, 1) ? -mag : mag;
                end
                p.particle_index = $urandom_range(0, 1023);
                p.frame_low      = $urandom_range(0, 255);
                send_particle(p, predict_colour(p, cur_red_speed));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : colour_sink
        int                  stall;
        logic [COLOUR_W-1:0] want;
        wait (rst_n);
        forever begin
            stall = snk_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (colour_q.size() == 0) begin
                errors++;
                $error("colour: unexpected transfer, got %h", m_tdata);
            end else begin
                want = colour_q.pop_front();
                if (m_tdata !== want) begin
                    errors++;
                    $error("colour mismatch: expected %h, got %h", want, m_tdata);
                end
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: particle_speed_colour_unit.f
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_front.sv
rtl/core/psc_div_stage.sv
rtl/core/psc_shade.sv
rtl/core/particle_speed_colour_unit.sv
rtl/core/psc_checker.sv
tb/sv/particle_speed_colour_unit_tb.sv
